@@ src/json_string_literal_decoder_core_assert.svh @@
// Assertion macros shared by the JSON string decoder RTL.
// Included by the modules that check their own control logic; needs nothing else.
`ifndef JSON_STRING_LITERAL_DECODER_CORE_ASSERT_SVH
`define JSON_STRING_LITERAL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JSLD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JSLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jsld_pkg.sv @@
// Package for the JSON string literal decoder: codes, character constants,
// state and result types, and the hex and UTF-8 encoding helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsld_pkg;

    // Phase codes of the decoder.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_STR     = 4'd1;
    localparam logic [3:0] PH_ESC     = 4'd2;
    localparam logic [3:0] PH_HEX1    = 4'd3;
    localparam logic [3:0] PH_SURR_BS = 4'd4;
    localparam logic [3:0] PH_SURR_U  = 4'd5;
    localparam logic [3:0] PH_HEX2    = 4'd6;
    localparam logic [3:0] PH_UTF8    = 4'd7;

    // Result kinds and failure codes.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [1:0] FAIL_NONE   = 2'd0;
    localparam logic [1:0] FAIL_SYNTAX = 2'd1;
    localparam logic [1:0] FAIL_UTF8   = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_ASCII_LIMIT = 8'h80;

    // UTF-8 lead and continuation byte bounds.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] CONT_E0_MIN = 8'hA0;
    localparam logic [7:0] CONT_ED_MAX = 8'h9F;
    localparam logic [7:0] CONT_F0_MIN = 8'h90;
    localparam logic [7:0] CONT_F4_MAX = 8'h8F;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPPL_BASE    = 21'h10000;

    localparam int unsigned MAX_RESULTS = 4;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] hex_acc;
        logic [1:0]  hex_cnt;
        logic [15:0] high_surr;
        logic [23:0] pend;
        logic [1:0]  need;
        logic [1:0]  seen;
    } jsld_state_t;

    localparam jsld_state_t STATE_CLEAR = '{
        phase: PH_IDLE, hex_acc: 16'd0, hex_cnt: 2'd0, high_surr: 16'd0,
        pend: 24'd0, need: 2'd0, seen: 2'd0
    };

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [1:0] code;
    } jsld_res_t;

    typedef struct packed {
        jsld_res_t [MAX_RESULTS-1:0] res;
        logic [2:0]                  cnt;
    } jsld_burst_t;

    // Bit 4 flags a valid hex digit, bits 3..0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Turns a code point into one to four UTF-8 bytes.
    function automatic jsld_burst_t utf8_encode(input logic [20:0] cp);
        jsld_burst_t b;
        b = '0;
        if (cp < 21'h80) begin
            b.res[0].data = cp[7:0];
            b.cnt = 3'd1;
        end else if (cp < 21'h800) begin
            b.res[0].data = {3'b110, cp[10:6]};
            b.res[1].data = {2'b10, cp[5:0]};
            b.cnt = 3'd2;
        end else if (cp < 21'h10000) begin
            b.res[0].data = {4'b1110, cp[15:12]};
            b.res[1].data = {2'b10, cp[11:6]};
            b.res[2].data = {2'b10, cp[5:0]};
            b.cnt = 3'd3;
        end else begin
            b.res[0].data = {5'b11110, cp[20:18]};
            b.res[1].data = {2'b10, cp[17:12]};
            b.res[2].data = {2'b10, cp[11:6]};
            b.res[3].data = {2'b10, cp[5:0]};
            b.cnt = 3'd4;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ src/json_string_literal_decoder_core.sv @@
// JSON string literal decoder, one raw byte per input item, with an input
// register and a multi-result output register. Depends on jsld_pkg,
// jsld_decode, jsld_burst and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_literal_decoder_core_assert.svh"

// The decoder takes a JSON string literal one byte per item and returns the
// decoded bytes. In idle it skips bytes until an opening quote; the closing
// quote gives one "closed" result, and any error gives one "failed" result
// with a syntax or UTF-8 code, after which the decoder is back in idle and the
// consumer should discard what it received of that string. Escapes are
// expanded, \uXXXX escapes (and joined surrogate pairs) come out as UTF-8, and
// raw multi-byte UTF-8 is checked strictly and released whole on its last
// byte. Every accepted item is held in an input register; the decode logic
// between that register and the result register is combinational, so items
// that yield zero or one result stream back to back while out_stall is low.
// An item that yields n results (up to four, for a four-byte UTF-8 sequence)
// occupies the result register until all n have been taken, and the input
// side raises in_stall once its register is full during that burst. The
// first result of an item is registered in the input register and then in
// the result register before it shows on the output. Items that yield no
// result (the opening quote, a backslash, hex digits, the leading bytes of a
// UTF-8 sequence) still pass through the same two stages.
module json_string_literal_decoder_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       input_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic [1:0]      fail_code,
    output logic            last_of_run
);

    // Input register.
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] data_reg;
    logic       end_reg;
    logic       accept;

    // Decoder state, updated when the held item moves into the result register.
    jsld_pkg::jsld_state_t state_reg;
    jsld_pkg::jsld_state_t state_next;
    jsld_pkg::jsld_burst_t burst;

    logic burst_ready;
    logic load;

    assign load     = in_vld_reg && burst_ready;
    assign in_stall = in_vld_reg && !load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept) begin
            in_vld_next = 1'b1;
        end else if (load) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            data_reg <= data_byte;
            end_reg  <= input_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= jsld_pkg::STATE_CLEAR;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    jsld_decode u_decode
    (
        .state      (state_reg),
        .data_byte  (data_reg),
        .input_end  (end_reg),
        .state_next (state_next),
        .burst      (burst)
    );

    jsld_burst u_burst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .burst       (burst),
        .ready       (burst_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .fail_code   (fail_code),
        .last_of_run (last_of_run)
    );

    // A held item that could not move on stays, unchanged, for the next cycle.
    `JSLD_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_vld_reg && !load, in_vld_reg && $stable(data_reg) && $stable(end_reg), "held input item was lost or changed")
    // A failure or close always returns the decoder to idle.
    `JSLD_ASSERT_NEXT(a_idle_after_end, clk, rst_n, load && burst.cnt == 3'd1 && burst.res[0].kind != jsld_pkg::KIND_BYTE, state_reg.phase == jsld_pkg::PH_IDLE, "decoder not idle after close or failure")

endmodule

`default_nettype wire

@@ src/jsld_decode.sv @@
// Next-state and result logic of the JSON string decoder for one input item.
// Depends on jsld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsld_decode
(
    input  var jsld_pkg::jsld_state_t state,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 input_end,
    output var jsld_pkg::jsld_state_t state_next,
    output var jsld_pkg::jsld_burst_t burst
);

    logic [4:0]  hex_d;
    logic [15:0] acc_new;
    logic [20:0] pair_cp;
    logic [7:0]  lo_bound;
    logic [7:0]  hi_bound;
    logic [1:0]  seen_new;
    logic        fail_en;
    logic [1:0]  fail_cd;

    assign hex_d    = jsld_pkg::hex_value(data_byte);
    assign acc_new  = {state.hex_acc[11:0], hex_d[3:0]};
    assign pair_cp  = {1'b0, state.high_surr[9:0], acc_new[9:0]} + jsld_pkg::SUPPL_BASE;
    assign seen_new = state.seen + 2'd1;

    // Allowed range of the next continuation byte; only the first one is narrowed.
    always_comb
    begin
        lo_bound = jsld_pkg::CONT_MIN;
        hi_bound = jsld_pkg::CONT_MAX;
        if (state.seen == 2'd0) begin
            if (state.pend[7:0] == jsld_pkg::LEAD_E0) begin
                lo_bound = jsld_pkg::CONT_E0_MIN;
            end else if (state.pend[7:0] == jsld_pkg::LEAD_ED) begin
                hi_bound = jsld_pkg::CONT_ED_MAX;
            end else if (state.pend[7:0] == jsld_pkg::LEAD4_MIN) begin
                lo_bound = jsld_pkg::CONT_F0_MIN;
            end else if (state.pend[7:0] == jsld_pkg::LEAD4_MAX) begin
                hi_bound = jsld_pkg::CONT_F4_MAX;
            end
        end
    end

    always_comb
    begin
        state_next = state;
        burst      = '0;
        fail_en    = 1'b0;
        fail_cd    = jsld_pkg::FAIL_NONE;

        if (state.phase == jsld_pkg::PH_IDLE || state.phase > jsld_pkg::PH_UTF8) begin
            state_next = jsld_pkg::STATE_CLEAR;
            if (!input_end && data_byte == jsld_pkg::CH_QUOTE) begin
                state_next.phase = jsld_pkg::PH_STR;
            end
        end else if (input_end) begin
            fail_en = 1'b1;
            if (state.phase == jsld_pkg::PH_SURR_BS || state.phase == jsld_pkg::PH_SURR_U ||
                state.phase == jsld_pkg::PH_UTF8) begin
                fail_cd = jsld_pkg::FAIL_UTF8;
            end else begin
                fail_cd = jsld_pkg::FAIL_SYNTAX;
            end
        end else begin
            unique case (state.phase)
                jsld_pkg::PH_STR:
                begin
                    if (data_byte == jsld_pkg::CH_QUOTE) begin
                        state_next = jsld_pkg::STATE_CLEAR;
                        burst.res[0].kind = jsld_pkg::KIND_CLOSE;
                        burst.cnt = 3'd1;
                    end else if (data_byte == jsld_pkg::CH_BSLASH) begin
                        state_next.phase = jsld_pkg::PH_ESC;
                    end else if (data_byte < jsld_pkg::CH_CTRL_LIMIT) begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_SYNTAX;
                    end else if (data_byte < jsld_pkg::CH_ASCII_LIMIT) begin
                        burst.res[0].data = data_byte;
                        burst.cnt = 3'd1;
                    end else if (data_byte >= jsld_pkg::LEAD2_MIN &&
                                 data_byte <= jsld_pkg::LEAD4_MAX) begin
                        if (data_byte <= jsld_pkg::LEAD2_MAX) begin
                            state_next.need = 2'd1;
                        end else if (data_byte <= jsld_pkg::LEAD3_MAX) begin
                            state_next.need = 2'd2;
                        end else begin
                            state_next.need = 2'd3;
                        end
                        state_next.pend  = {16'd0, data_byte};
                        state_next.seen  = 2'd0;
                        state_next.phase = jsld_pkg::PH_UTF8;
                    end else begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_UTF8;
                    end
                end
                jsld_pkg::PH_UTF8:
                begin
                    if (data_byte < lo_bound || data_byte > hi_bound) begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_UTF8;
                    end else if (seen_new >= state.need) begin
                        // Sequence complete: release the held bytes and this one.
                        for (int k = 0; k < 3; k++) begin
                            if (2'(k) < state.need) begin
                                burst.res[k].data = state.pend[8*k +: 8];
                            end
                        end
                        burst.res[state.need].data = data_byte;
                        burst.cnt = {1'b0, state.need} + 3'd1;
                        state_next = jsld_pkg::STATE_CLEAR;
                        state_next.phase = jsld_pkg::PH_STR;
                    end else begin
                        state_next.seen = seen_new;
                        unique case (seen_new)
                            2'd0: state_next.pend[7:0]   = state.pend[7:0] | data_byte;
                            2'd1: state_next.pend[15:8]  = state.pend[15:8] | data_byte;
                            2'd2: state_next.pend[23:16] = state.pend[23:16] | data_byte;
                            default: state_next.pend = state.pend;
                        endcase
                    end
                end
                jsld_pkg::PH_ESC:
                begin
                    state_next.phase = jsld_pkg::PH_STR;
                    burst.cnt = 3'd1;
                    unique case (data_byte)
                        jsld_pkg::CH_QUOTE:  burst.res[0].data = jsld_pkg::CH_QUOTE;
                        jsld_pkg::CH_BSLASH: burst.res[0].data = jsld_pkg::CH_BSLASH;
                        jsld_pkg::CH_SLASH:  burst.res[0].data = jsld_pkg::CH_SLASH;
                        jsld_pkg::CH_LC_B:   burst.res[0].data = 8'h08;
                        jsld_pkg::CH_LC_F:   burst.res[0].data = 8'h0C;
                        jsld_pkg::CH_LC_N:   burst.res[0].data = 8'h0A;
                        jsld_pkg::CH_LC_R:   burst.res[0].data = 8'h0D;
                        jsld_pkg::CH_LC_T:   burst.res[0].data = 8'h09;
                        jsld_pkg::CH_LC_U:
                        begin
                            burst.cnt = 3'd0;
                            state_next.hex_acc = 16'd0;
                            state_next.hex_cnt = 2'd0;
                            state_next.phase   = jsld_pkg::PH_HEX1;
                        end
                        default:
                        begin
                            fail_en = 1'b1;
                            fail_cd = jsld_pkg::FAIL_SYNTAX;
                        end
                    endcase
                end
                jsld_pkg::PH_HEX1, jsld_pkg::PH_HEX2:
                begin
                    if (!hex_d[4]) begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_SYNTAX;
                    end else if (state.hex_cnt != 2'd3) begin
                        state_next.hex_acc = acc_new;
                        state_next.hex_cnt = state.hex_cnt + 2'd1;
                    end else begin
                        state_next.hex_acc = acc_new;
                        state_next.hex_cnt = 2'd0;
                        if (state.phase == jsld_pkg::PH_HEX1) begin
                            if (acc_new >= jsld_pkg::HIGH_SURR_MIN &&
                                acc_new <= jsld_pkg::HIGH_SURR_MAX) begin
                                state_next.high_surr = acc_new;
                                state_next.phase     = jsld_pkg::PH_SURR_BS;
                            end else if (acc_new >= jsld_pkg::LOW_SURR_MIN &&
                                         acc_new <= jsld_pkg::LOW_SURR_MAX) begin
                                fail_en = 1'b1;
                                fail_cd = jsld_pkg::FAIL_UTF8;
                            end else begin
                                state_next.phase = jsld_pkg::PH_STR;
                                burst = jsld_pkg::utf8_encode({5'd0, acc_new});
                            end
                        end else begin
                            if (acc_new < jsld_pkg::LOW_SURR_MIN ||
                                acc_new > jsld_pkg::LOW_SURR_MAX) begin
                                fail_en = 1'b1;
                                fail_cd = jsld_pkg::FAIL_UTF8;
                            end else begin
                                state_next.high_surr = 16'd0;
                                state_next.phase     = jsld_pkg::PH_STR;
                                burst = jsld_pkg::utf8_encode(pair_cp);
                            end
                        end
                    end
                end
                jsld_pkg::PH_SURR_BS:
                begin
                    if (data_byte != jsld_pkg::CH_BSLASH) begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_UTF8;
                    end else begin
                        state_next.phase = jsld_pkg::PH_SURR_U;
                    end
                end
                jsld_pkg::PH_SURR_U:
                begin
                    if (data_byte != jsld_pkg::CH_LC_U) begin
                        fail_en = 1'b1;
                        fail_cd = jsld_pkg::FAIL_UTF8;
                    end else begin
                        state_next.hex_acc = 16'd0;
                        state_next.hex_cnt = 2'd0;
                        state_next.phase   = jsld_pkg::PH_HEX2;
                    end
                end
                default:
                begin
                    state_next = jsld_pkg::STATE_CLEAR;
                end
            endcase
        end

        // Any failure ends the string with a single failure result.
        if (fail_en) begin
            state_next = jsld_pkg::STATE_CLEAR;
            burst = '0;
            burst.res[0].kind = jsld_pkg::KIND_FAIL;
            burst.res[0].code = fail_cd;
            burst.cnt = 3'd1;
        end
    end

endmodule

`default_nettype wire

@@ src/jsld_burst.sv @@
// Result register of the JSON string decoder: holds the results of one item
// and hands them out one per cycle while out_stall is low. Depends on jsld_pkg and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_literal_decoder_core_assert.svh"

module jsld_burst
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  var jsld_pkg::jsld_burst_t burst,
    output logic                      ready,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic [1:0]                out_kind,
    output logic [1:0]                fail_code,
    output logic                      last_of_run
);

    jsld_pkg::jsld_res_t [jsld_pkg::MAX_RESULTS-1:0] res_reg;
    logic [2:0] rem_reg;
    logic [2:0] rem_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign out_valid   = (rem_reg != 3'd0);
    assign take        = out_valid && !out_stall;
    // A new burst may load when none is held, or once the last held result leaves in this cycle.
    assign ready       = (rem_reg == 3'd0) || (rem_reg == 3'd1 && !out_stall);
    assign out_byte    = res_reg[idx_reg].data;
    assign out_kind    = res_reg[idx_reg].kind;
    assign fail_code   = res_reg[idx_reg].code;
    assign last_of_run = (rem_reg == 3'd1);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load) begin
            rem_next = burst.cnt;
            idx_next = 2'd0;
        end else if (take) begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= burst.res;
        end
    end

    `JSLD_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid && out_kind != jsld_pkg::KIND_BYTE, last_of_run, "close or failure result is not the last of its run")
    `JSLD_ASSERT_NOW(a_fail_has_code, clk, rst_n, out_valid && out_kind == jsld_pkg::KIND_FAIL, fail_code != jsld_pkg::FAIL_NONE, "failure result without a failure code")
    `JSLD_ASSERT_NOW(a_no_stray_code, clk, rst_n, out_valid && out_kind != jsld_pkg::KIND_FAIL, fail_code == jsld_pkg::FAIL_NONE && (out_kind == jsld_pkg::KIND_BYTE || out_byte == 8'd0), "stray failure code or byte on a result")
    `JSLD_ASSERT_NEXT(a_load_when_ready, clk, rst_n, load && !ready, 1'b0, "burst loaded while results were still held")

endmodule

`default_nettype wire
